// File: rtl/ptjsl_pkg.sv
// ----------------------------------------------------------------------------
// ptjsl_pkg
// Shared constants, command types and arithmetic helpers for the pose to
// joint slew limiter.
// ----------------------------------------------------------------------------
package ptjsl_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int CORDIC_STEPS = 14;
    localparam int GUARD_BITS   = 14;
    localparam int CNT_W        = 5;
    localparam int NUM_JOINTS   = 6;
    localparam int HYP_SHIFT    = GUARD_BITS + 30;
    localparam int ANG_SHIFT    = 30 - FRAC_BITS;

    localparam int C_0P8  = (8 * (2 ** (FRAC_BITS + 1)) + 10) / 20;
    localparam int C_0P9  = (9 * (2 ** (FRAC_BITS + 1)) + 10) / 20;
    localparam int C_2P2  = (22 * (2 ** (FRAC_BITS + 1)) + 10) / 20;
    localparam int C_0P5  = (5 * (2 ** (FRAC_BITS + 1)) + 10) / 20;
    localparam int C_1P2  = (12 * (2 ** (FRAC_BITS + 1)) + 10) / 20;
    localparam int C_0P6  = (6 * (2 ** (FRAC_BITS + 1)) + 10) / 20;
    localparam int C_2P5  = (25 * (2 ** (FRAC_BITS + 1)) + 10) / 20;
    localparam int C_1P57 = (157 * (2 ** (FRAC_BITS + 1)) + 100) / 200;
    localparam int C_0P3  = (3 * (2 ** (FRAC_BITS + 1)) + 10) / 20;
    localparam int C_0P25 = (25 * (2 ** (FRAC_BITS + 1)) + 100) / 200;
    localparam int C_1P0  = 2 ** FRAC_BITS;
    localparam int C_1P8  = (18 * (2 ** (FRAC_BITS + 1)) + 10) / 20;
    localparam int C_1P6  = (16 * (2 ** (FRAC_BITS + 1)) + 10) / 20;

    localparam logic signed [31:0] HYP_GAIN = 32'sd521626299;
    localparam logic signed [33:0] HALF_PI  = 34'sd1686629713;

    localparam logic [30:0] NSEC_WRAP  = 31'd1000000000;
    localparam logic [30:0] NSEC_WRAP2 = 31'd2000000000;
    localparam logic [29:0] NSEC_MAX   = 30'd999999999;
    localparam logic [32:0] SEC_MAX    = 33'd2147483647;

    localparam logic [1:0] REG_STEP_LIMIT = 2'd0;
    localparam logic [1:0] REG_STEP_SEC   = 2'd1;
    localparam logic [1:0] REG_STEP_NSEC  = 2'd2;

    typedef struct packed {
        logic             load;
        logic             cord;
        logic             mul;
        logic             lim;
        logic             tstep;
        logic             oload;
        logic [CNT_W-1:0] idx;
    } t_cmd;

    function automatic logic signed [15:0] home_joint(input logic [2:0] j);
        logic signed [15:0] v;
        case (j)
            3'd1:    v = -16'(C_1P2);
            3'd2:    v = 16'(C_1P8);
            3'd3:    v = -16'(C_1P6);
            3'd4:    v = -16'(C_1P57);
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [33:0] atan_q30(input logic [CNT_W-1:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:    v = 34'sd843314857;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043837;
            5'd3:    v = 34'sd133525159;
            5'd4:    v = 34'sd67021687;
            5'd5:    v = 34'sd33543516;
            5'd6:    v = 34'sd16775851;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194283;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048576;
            5'd11:   v = 34'sd524288;
            5'd12:   v = 34'sd262144;
            5'd13:   v = 34'sd131072;
            5'd14:   v = 34'sd65536;
            5'd15:   v = 34'sd32768;
            5'd16:   v = 34'sd16384;
            5'd17:   v = 34'sd8192;
            5'd18:   v = 34'sd4096;
            5'd19:   v = 34'sd2048;
            5'd20:   v = 34'sd1024;
            5'd21:   v = 34'sd512;
            5'd22:   v = 34'sd256;
            5'd23:   v = 34'sd128;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // Rounds to nearest with ties away from zero.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input logic [5:0] s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (s - 6'd1);
        if (v >= 0) begin
            return (v + half) >>> s;
        end
        return (v + half - 64'sd1) >>> s;
    endfunction

    function automatic logic signed [19:0] clamp20(input logic signed [19:0] v,
                                                   input logic signed [19:0] lo,
                                                   input logic signed [19:0] hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

endpackage

// File: rtl/ptjsl_ctrl.sv
// ----------------------------------------------------------------------------
// ptjsl_ctrl
// Sequencer: accepts an item, runs the CORDIC iterations, then a multiply and
// a limit step per joint, advances the time and hands the result out.
// ----------------------------------------------------------------------------
module ptjsl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output ptjsl_pkg::t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CORD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_LIM  = 3'd3;
    localparam logic [2:0] ST_TIME = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]                 r_state, n_state;
    logic [ptjsl_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       r_valid, n_valid;
    logic                       w_take;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_valid;
    assign w_take     = (r_state == ST_OUT) && (!r_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = r_valid;
        if (r_valid && i_m_tready) begin
            n_valid = 1'b0;
        end
        o_cmd       = '0;
        o_cmd.idx   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_CORD;
                end
            end
            ST_CORD: begin
                o_cmd.cord = 1'b1;
                if (r_cnt == ptjsl_pkg::CNT_W'(ptjsl_pkg::CORDIC_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_MUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_LIM;
            end
            ST_LIM: begin
                o_cmd.lim = 1'b1;
                if (r_cnt == ptjsl_pkg::CNT_W'(ptjsl_pkg::NUM_JOINTS - 1)) begin
                    n_state = ST_TIME;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_TIME: begin
                o_cmd.tstep = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (w_take) begin
                    o_cmd.oload = 1'b1;
                    n_valid     = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

endmodule

// File: rtl/ptjsl_dp.sv
// ----------------------------------------------------------------------------
// ptjsl_dp
// Datapath: configuration registers, CORDIC vectoring unit, shared multiplier,
// joint clamp and slew limit, joint history, limit count and timestamp.
// ----------------------------------------------------------------------------
module ptjsl_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptjsl_pkg::t_cmd i_cmd,
    input  logic            i_cfg_valid,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data,
    input  logic            i_first_pose,
    input  logic [47:0]     i_pos,
    output logic [175:0]    o_tdata,
    output logic            o_tuser
);

    logic [14:0] r_step_limit;
    logic [15:0] r_step_sec;
    logic [29:0] r_step_nsec;

    logic signed [15:0] r_px, r_py, r_pz;
    logic               r_origin;
    logic signed [33:0] r_x, r_y, r_z;
    logic signed [63:0] r_prod;
    logic signed [15:0] r_joint [ptjsl_pkg::NUM_JOINTS];
    logic               r_any;
    logic [15:0]        r_total;
    logic [30:0]        r_sec;
    logic [29:0]        r_nsec;
    logic [175:0]       r_odata;
    logic               r_ouser;

    logic signed [15:0] w_px, w_py, w_pz;
    logic signed [33:0] w_x0, w_y0, w_ix, w_iy, w_iz;
    logic signed [33:0] w_dx, w_dy;
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_rv64;
    logic signed [19:0] w_rv, w_tgt, w_sat, w_prev, w_ms, w_d, w_q;
    logic               w_lim;
    logic [2:0]         w_j;
    logic [30:0]        w_ns0;
    logic [32:0]        w_sec0;
    logic [29:0]        w_ns;
    logic [32:0]        w_sec;

    assign w_px = i_pos[15:0];
    assign w_py = i_pos[31:16];
    assign w_pz = i_pos[47:32];
    assign w_j  = i_cmd.idx[2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= 15'd410;
            r_step_sec   <= 16'd0;
            r_step_nsec  <= 30'd100000000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ptjsl_pkg::REG_STEP_LIMIT: r_step_limit <= i_cfg_data[14:0];
                ptjsl_pkg::REG_STEP_SEC:   r_step_sec   <= i_cfg_data[15:0];
                ptjsl_pkg::REG_STEP_NSEC:  r_step_nsec  <= i_cfg_data[29:0];
                default: begin
                end
            endcase
        end
    end

    // The left half plane is rotated by a quarter turn before the iterations.
    always_comb begin
        w_x0 = 34'(w_px) <<< ptjsl_pkg::GUARD_BITS;
        w_y0 = 34'(w_py) <<< ptjsl_pkg::GUARD_BITS;
        w_ix = w_x0;
        w_iy = w_y0;
        w_iz = '0;
        if (w_x0 < 0) begin
            if (w_y0 >= 0) begin
                w_ix = w_y0;
                w_iy = -w_x0;
                w_iz = ptjsl_pkg::HALF_PI;
            end else begin
                w_ix = -w_y0;
                w_iy = w_x0;
                w_iz = -ptjsl_pkg::HALF_PI;
            end
        end
    end

    assign w_dx = r_y >>> i_cmd.idx;
    assign w_dy = r_x >>> i_cmd.idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px     <= w_px;
            r_py     <= w_py;
            r_pz     <= w_pz;
            r_origin <= (w_px == 16'sd0) && (w_py == 16'sd0);
            r_x      <= w_ix;
            r_y      <= w_iy;
            r_z      <= w_iz;
        end else if (i_cmd.cord) begin
            if (r_y >= 0) begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + ptjsl_pkg::atan_q30(i_cmd.idx);
            end else begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - ptjsl_pkg::atan_q30(i_cmd.idx);
            end
        end
    end

    always_comb begin
        case (w_j)
            3'd1: begin
                w_ma = 32'(r_pz);
                w_mb = 32'(ptjsl_pkg::C_0P9);
            end
            3'd2: begin
                w_ma = r_x[31:0];
                w_mb = ptjsl_pkg::HYP_GAIN;
            end
            3'd3: begin
                w_ma = 32'(r_pz);
                w_mb = 32'(ptjsl_pkg::C_0P6);
            end
            3'd4: begin
                w_ma = 32'(r_py);
                w_mb = 32'(ptjsl_pkg::C_0P3);
            end
            3'd5: begin
                w_ma = 32'(r_px);
                w_mb = 32'(ptjsl_pkg::C_0P25);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= 64'(w_ma) * 64'(w_mb);
        end
    end

    always_comb begin
        case (w_j)
            3'd0:    w_rv64 = ptjsl_pkg::round_shift(64'(r_z), 6'(ptjsl_pkg::ANG_SHIFT));
            3'd2:    w_rv64 = ptjsl_pkg::round_shift(r_prod, 6'(ptjsl_pkg::HYP_SHIFT));
            default: w_rv64 = ptjsl_pkg::round_shift(r_prod, 6'(ptjsl_pkg::FRAC_BITS));
        endcase
        w_rv = w_rv64[19:0];
        case (w_j)
            3'd0: begin
                w_tgt = r_origin ? 20'sd0 : w_rv;
            end
            3'd1: begin
                w_tgt = ptjsl_pkg::clamp20(-20'(ptjsl_pkg::C_0P8) - w_rv,
                                           -20'(ptjsl_pkg::C_2P2), 20'(ptjsl_pkg::C_0P5));
            end
            3'd2: begin
                w_tgt = ptjsl_pkg::clamp20(20'(ptjsl_pkg::C_1P0) + w_rv,
                                           -20'(ptjsl_pkg::C_2P2), 20'(ptjsl_pkg::C_2P2));
            end
            3'd3: begin
                w_tgt = ptjsl_pkg::clamp20(-20'(ptjsl_pkg::C_1P2) - w_rv,
                                           -20'(ptjsl_pkg::C_2P5), 20'(ptjsl_pkg::C_0P5));
            end
            3'd4: begin
                w_tgt = ptjsl_pkg::clamp20(-20'(ptjsl_pkg::C_1P57) + w_rv,
                                           -20'(ptjsl_pkg::C_2P2), 20'(ptjsl_pkg::C_2P2));
            end
            default: begin
                w_tgt = ptjsl_pkg::clamp20(w_rv,
                                           -20'(ptjsl_pkg::C_2P2), 20'(ptjsl_pkg::C_2P2));
            end
        endcase
        w_sat  = ptjsl_pkg::clamp20(w_tgt, -20'sd32768, 20'sd32767);
        w_prev = 20'(r_joint[w_j]);
        w_ms   = 20'($signed({1'b0, r_step_limit}));
        w_d    = w_sat - w_prev;
        w_q    = w_sat;
        w_lim  = 1'b0;
        if (w_d > w_ms) begin
            w_q   = w_prev + w_ms;
            w_lim = 1'b1;
        end else if (w_d < -w_ms) begin
            w_q   = w_prev - w_ms;
            w_lim = 1'b1;
        end
    end

    always_comb begin
        w_ns0  = 31'(r_nsec) + 31'(r_step_nsec);
        w_sec0 = 33'(r_sec) + 33'(r_step_sec);
        if (w_ns0 >= ptjsl_pkg::NSEC_WRAP2) begin
            w_ns  = 30'(w_ns0 - ptjsl_pkg::NSEC_WRAP2);
            w_sec = w_sec0 + 33'd2;
        end else if (w_ns0 >= ptjsl_pkg::NSEC_WRAP) begin
            w_ns  = 30'(w_ns0 - ptjsl_pkg::NSEC_WRAP);
            w_sec = w_sec0 + 33'd1;
        end else begin
            w_ns  = w_ns0[29:0];
            w_sec = w_sec0;
        end
        if (w_sec > ptjsl_pkg::SEC_MAX) begin
            w_sec = ptjsl_pkg::SEC_MAX;
            w_ns  = ptjsl_pkg::NSEC_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ptjsl_pkg::NUM_JOINTS; k++) begin
                r_joint[k] <= ptjsl_pkg::home_joint(3'(k));
            end
            r_total <= '0;
            r_sec   <= '0;
            r_nsec  <= '0;
            r_any   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_any <= 1'b0;
                if (i_first_pose) begin
                    for (int k = 0; k < ptjsl_pkg::NUM_JOINTS; k++) begin
                        r_joint[k] <= ptjsl_pkg::home_joint(3'(k));
                    end
                    r_total <= '0;
                    r_sec   <= '0;
                    r_nsec  <= '0;
                end
            end
            if (i_cmd.lim) begin
                r_joint[w_j] <= w_q[15:0];
                if (w_lim) begin
                    r_any <= 1'b1;
                end
            end
            if (i_cmd.tstep) begin
                if (r_any && (r_total != 16'hFFFF)) begin
                    r_total <= r_total + 16'd1;
                end
                r_sec  <= w_sec[30:0];
                r_nsec <= w_ns;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.oload) begin
            r_odata <= {3'b000, r_nsec, r_sec, r_total, r_joint[5], r_joint[4],
                        r_joint[3], r_joint[2], r_joint[1], r_joint[0]};
            r_ouser <= r_any;
        end
    end

    assign o_tdata = r_odata;
    assign o_tuser = r_ouser;

endmodule

// File: rtl/pose_to_joint_slew_limiter_top.sv
// ----------------------------------------------------------------------------
// pose_to_joint_slew_limiter_top
// Maps Cartesian positions to six slew-limited joint commands with a
// limited-point count and an accumulated timestamp.
// ----------------------------------------------------------------------------
// One item is worked at a time. Once it is accepted, it goes through CORDIC_STEPS
// vectoring steps in the single shift-add unit, a multiply step and a limit step
// for each of the six joints through the one shared multiplier, a timestamp step,
// and a step that registers the result, which waits while the last result is
// still held unaccepted. The next item is taken in the cycle after the result is
// registered, even while it waits, so no new item is accepted before the last
// one's result is registered.
module pose_to_joint_slew_limiter_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // pos_x, pos_y, pos_z
    input  logic [47:0]   i_s_tdata,
    // first_pose
    input  logic          i_s_tuser,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // joint_base, joint_shoulder, joint_elbow, joint_wrist_one, joint_wrist_two,
    // joint_wrist_three, limited_points, time_sec, time_nsec, zero fill
    output logic [175:0]  o_m_tdata,
    // step_limited
    output logic          o_m_tuser,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    ptjsl_pkg::t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    ptjsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    ptjsl_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_first_pose (i_s_tuser),
        .i_pos        (i_s_tdata),
        .o_tdata      (o_m_tdata),
        .o_tuser      (o_m_tuser)
    );

endmodule

// File: rtl/ptjsl_checker.sv
// ----------------------------------------------------------------------------
// ptjsl_checker
// Port-level checks of the slew limiter, bound to the top level.
// ----------------------------------------------------------------------------
module ptjsl_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [175:0] o_m_tdata,
    input logic         o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("Result item dropped before it was taken.");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Result valid after reset.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("Second item accepted while one is at work.");

    a_nsec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[172:143] < 30'd1000000000))
        else $error("Nanosecond field out of range.");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> (o_m_tdata[111:96] != 16'd0))
        else $error("Limited item with a zero count.");

endmodule

bind pose_to_joint_slew_limiter_top ptjsl_checker u_ptjsl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pose to joint slew limiter. Positions are sent
// through the input stream under several idle and stall patterns, and a
// scoreboard predicts the joint commands, limit flag, count and timestamp of
// each point and compares them with the output stream.
// ----------------------------------------------------------------------------
module tb;

    localparam longint NS_WRAP = 1000000000;
    localparam longint SEC_TOP = 2147483647;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct {
        logic signed [15:0] joint [6];
        logic               limited;
        logic [15:0]        count;
        logic [30:0]        sec;
        logic [29:0]        nsec;
    } t_point;

    class joint_scoreboard;
        longint      step_limit;
        longint      whole_sec;
        longint      nsec_step;
        longint      prev_joint [6];
        longint      limited_total;
        longint      elapsed_sec;
        longint      elapsed_nsec;
        t_point      pending [$];
        int          errors;
        string       joint_name [6];

        function new();
            step_limit = 410;
            whole_sec = 0;
            nsec_step = 100000000;
            errors = 0;
            joint_name[0] = "joint_base";
            joint_name[1] = "joint_shoulder";
            joint_name[2] = "joint_elbow";
            joint_name[3] = "joint_wrist_one";
            joint_name[4] = "joint_wrist_two";
            joint_name[5] = "joint_wrist_three";
            go_home();
        endfunction

        function void go_home();
            prev_joint[0] = 0;
            prev_joint[1] = -ptjsl_pkg::C_1P2;
            prev_joint[2] = ptjsl_pkg::C_1P8;
            prev_joint[3] = -ptjsl_pkg::C_1P6;
            prev_joint[4] = -ptjsl_pkg::C_1P57;
            prev_joint[5] = 0;
            limited_total = 0;
            elapsed_sec = 0;
            elapsed_nsec = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                ptjsl_pkg::REG_STEP_LIMIT: step_limit = val[14:0];
                ptjsl_pkg::REG_STEP_SEC:   whole_sec = val[15:0];
                ptjsl_pkg::REG_STEP_NSEC:  nsec_step = val[29:0];
                default: ;
            endcase
        endfunction

        function longint rnd(longint v, int s);
            longint h;
            h = longint'(1) <<< (s - 1);
            if (v >= 0) return (v + h) >>> s;
            return -((-v + h) >>> s);
        endfunction

        function longint lim(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void vector(longint x0, longint y0, output longint ang, output longint mag);
            longint x, y, z, t, dx, dy;
            longint atan_tab [14] = '{843314857, 497837829, 263043837, 133525159,
                67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                524288, 262144, 131072};
            x = x0 * 16384;
            y = y0 * 16384;
            z = 0;
            ang = 0;
            mag = 0;
            if (x0 == 0 && y0 == 0) return;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = 1686629713;
                end else begin
                    t = x; x = -y; y = t; z = -1686629713;
                end
            end
            for (int i = 0; i < ptjsl_pkg::CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += atan_tab[i];
                end else begin
                    x -= dx; y += dy; z -= atan_tab[i];
                end
            end
            ang = z;
            mag = x;
        endfunction

        function void note_pose(logic first, logic signed [15:0] px,
                                logic signed [15:0] py, logic signed [15:0] pz);
            longint tgt [6];
            longint ang, mag, d, q, ns, sec;
            t_point p;
            bit any;
            any = 0;
            if (first) go_home();
            vector(px, py, ang, mag);
            tgt[0] = rnd(ang, 30 - ptjsl_pkg::FRAC_BITS);
            tgt[1] = lim(-ptjsl_pkg::C_0P8 - rnd(pz * ptjsl_pkg::C_0P9, ptjsl_pkg::FRAC_BITS),
                         -ptjsl_pkg::C_2P2, ptjsl_pkg::C_0P5);
            tgt[2] = lim(ptjsl_pkg::C_1P0 + rnd(mag * 521626299, 44),
                         -ptjsl_pkg::C_2P2, ptjsl_pkg::C_2P2);
            tgt[3] = lim(-ptjsl_pkg::C_1P2 - rnd(pz * ptjsl_pkg::C_0P6, ptjsl_pkg::FRAC_BITS),
                         -ptjsl_pkg::C_2P5, ptjsl_pkg::C_0P5);
            tgt[4] = lim(-ptjsl_pkg::C_1P57 + rnd(py * ptjsl_pkg::C_0P3, ptjsl_pkg::FRAC_BITS),
                         -ptjsl_pkg::C_2P2, ptjsl_pkg::C_2P2);
            tgt[5] = lim(rnd(px * ptjsl_pkg::C_0P25, ptjsl_pkg::FRAC_BITS),
                         -ptjsl_pkg::C_2P2, ptjsl_pkg::C_2P2);
            for (int j = 0; j < 6; j++) begin
                d = lim(tgt[j], -32768, 32767) - prev_joint[j];
                q = prev_joint[j] + d;
                if (d > step_limit) begin
                    q = prev_joint[j] + step_limit; any = 1;
                end else if (d < -step_limit) begin
                    q = prev_joint[j] - step_limit; any = 1;
                end
                prev_joint[j] = q;
                p.joint[j] = q[15:0];
            end
            if (any && limited_total < 65535) limited_total++;
            ns = elapsed_nsec + nsec_step;
            sec = elapsed_sec + whole_sec;
            while (ns >= NS_WRAP) begin
                ns -= NS_WRAP; sec++;
            end
            if (sec > SEC_TOP) begin
                sec = SEC_TOP; ns = NS_WRAP - 1;
            end
            elapsed_sec = sec;
            elapsed_nsec = ns;
            p.limited = any;
            p.count = limited_total[15:0];
            p.sec = sec[30:0];
            p.nsec = ns[29:0];
            pending = {pending, p};
        endfunction

        function void check_result(logic [175:0] data, logic flag);
            t_point e;
            if (pending.size() == 0) begin
                $error("result with no point pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int j = 0; j < 6; j++) begin
                if (data[16*j +: 16] !== e.joint[j]) begin
                    $error("%s expected %0d actual %0d", joint_name[j], e.joint[j],
                           $signed(data[16*j +: 16]));
                    errors++;
                end
            end
            if (flag !== e.limited) begin
                $error("step_limited expected %0d actual %0d", e.limited, flag);
                errors++;
            end
            if (data[111:96] !== e.count) begin
                $error("limited_points expected %0d actual %0d", e.count, data[111:96]);
                errors++;
            end
            if (data[142:112] !== e.sec) begin
                $error("time_sec expected %0d actual %0d", e.sec, data[142:112]);
                errors++;
            end
            if (data[172:143] !== e.nsec) begin
                $error("time_nsec expected %0d actual %0d", e.nsec, data[172:143]);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_s_tvalid;
    logic          o_s_tready;
    logic [47:0]   i_s_tdata;
    logic          i_s_tuser;
    logic          o_m_tvalid;
    logic          i_m_tready;
    logic [175:0]  o_m_tdata;
    logic          o_m_tuser;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index;
    logic [31:0]   i_cfg_data;

    joint_scoreboard board;
    int  send_idle_pct;
    int  stall_pct;
    longint cycles;

    pose_to_joint_slew_limiter_top u_dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_result(o_m_tdata, o_m_tuser);
        end
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_pose(logic first, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= first;
        i_s_tdata <= {z, y, x};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_pose(first, x, y, z);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(24576)) - 12288);
            default: return 16'($signed($urandom_range(2048)) - 1024);
        endcase
    endfunction

    task automatic random_poses(int n);
        int m;
        for (int k = 0; k < n; k++) begin
            m = $urandom_range(2);
            send_pose($urandom_range(19) == 0, rand_coord(m), rand_coord(m), rand_coord(m));
        end
    endtask

    initial begin
        board = new();
        send_idle_pct = 0;
        stall_pct = 0;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= ptjsl_pkg::REG_STEP_LIMIT;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points: origin, axes, negative x, extremes.
        send_pose(1'b0, 16'h0000, 16'h0000, 16'h0000);
        send_pose(1'b0, 16'h7fff, 16'h0000, 16'h7fff);
        send_pose(1'b0, 16'h8000, 16'h0000, 16'h8000);
        send_pose(1'b0, 16'h8000, 16'h8000, 16'h0000);
        send_pose(1'b0, 16'hf000, 16'h1000, 16'h1000);
        send_pose(1'b1, 16'h7fff, 16'h7fff, 16'h7fff);
        send_pose(1'b0, 16'h8000, 16'h7fff, 16'hffff);
        send_pose(1'b0, 16'h0000, 16'h8000, 16'h0001);
        send_pose(1'b1, 16'hffff, 16'hffff, 16'h5555);
        send_pose(1'b0, 16'haaaa, 16'h5555, 16'haaaa);
        wait_drained();

        write_reg(ptjsl_pkg::REG_STEP_LIMIT, 32'd0);
        write_reg(ptjsl_pkg::REG_STEP_SEC, 32'd65535);
        write_reg(ptjsl_pkg::REG_STEP_NSEC, 32'd999999999);
        write_reg(REG_NONE, 32'hffffffff);
        send_pose(1'b1, 16'h1234, 16'h4321, 16'h0800);
        random_poses(12);
        wait_drained();

        // The nanosecond step is longer than a whole second, so time can carry twice; full step width allows any move.
        write_reg(ptjsl_pkg::REG_STEP_LIMIT, 32'h7fff);
        write_reg(ptjsl_pkg::REG_STEP_NSEC, 32'h3fffffff);
        write_reg(ptjsl_pkg::REG_STEP_SEC, 32'd65535);
        send_pose(1'b0, 16'h0100, 16'h0100, 16'h0100);
        wait_drained();

        write_reg(ptjsl_pkg::REG_STEP_LIMIT, 32'd410);
        write_reg(ptjsl_pkg::REG_STEP_SEC, 32'd0);
        write_reg(ptjsl_pkg::REG_STEP_NSEC, 32'd100000000);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 69 : 27) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 69 : 27) : 0;
            random_poses(200);
            wait_drained();
            write_reg(ptjsl_pkg::REG_STEP_LIMIT,
                      ph[0] ? 32'($urandom_range(32767)) : 32'($urandom_range(800)));
            write_reg(ptjsl_pkg::REG_STEP_SEC, 32'($urandom_range(3)));
            write_reg(ptjsl_pkg::REG_STEP_NSEC, 32'($urandom_range(999999999)));
            random_poses(200);
            wait_drained();
        end
        send_idle_pct = 0;
        stall_pct = 0;
        write_reg(ptjsl_pkg::REG_STEP_LIMIT, 32'd1);
        random_poses(60);
        wait_drained();

        if (board.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
